// ===== hdl/ymr_pkg.sv =====
// Package for the YMODEM image receiver: protocol byte codes, phases,
// function codes, status codes and the CRC byte-step functions.
// No dependencies.
`default_nettype none
package ymr_pkg;

   localparam int unsigned TimerBitsDefault = 16;
   localparam int unsigned SizeBitsDefault  = 32;

   // protocol bytes
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_REQ = 8'h43;

   localparam logic [10:0] IDX_MAX = 11'd2047;

   typedef enum logic [1:0] {
      FN_START = 2'd0,
      FN_BYTE  = 2'd1,
      FN_END   = 2'd2,
      FN_TICK  = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_HEAD = 4'b0010,
      PH_DATA = 4'b0100,
      PH_EOT  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      HF_NAME  = 2'd0,
      HF_ZERO  = 2'd1,
      HF_DIGIT = 2'd2,
      HF_DONE  = 2'd3
   } hfield_type;

   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_OK       = 3'd1;
   localparam logic [2:0] ST_TIMEOUT  = 3'd2;
   localparam logic [2:0] ST_CANCEL   = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;
   localparam logic [2:0] ST_MISMATCH = 3'd5;

   localparam logic [2:0] REG_MAX_SIZE  = 3'd0;
   localparam logic [2:0] REG_BASE      = 3'd1;
   localparam logic [2:0] REG_HEAD_WAIT = 3'd2;
   localparam logic [2:0] REG_DATA_WAIT = 3'd3;
   localparam logic [2:0] REG_RETRY     = 3'd4;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        wr_valid;
      logic [31:0] wr_address;
      logic [7:0]  wr_byte;
      logic        commit_valid;
      logic        commit_accept;
      logic [2:0]  session_status;
      logic [31:0] image_size;
      logic [31:0] image_crc;
      logic        last;
   } result_type;

   // CRC-16/XMODEM, one byte, MSB first
   function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
      end
      return r;
   endfunction

   // CRC-32 reflected, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/ymr_if.sv =====
// Valid/ready channel interface carrying one packed payload.
// No dependencies.
`default_nettype none
interface ymr_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/ymr_out_queue.sv =====
// Two-entry result queue: takes up to two results per cycle, gives one.
// Depends on ymr_pkg.
`default_nettype none
module ymr_out_queue
   import ymr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push0,
   input  wire logic       push1,
   input  wire result_type data0,
   input  wire result_type data1,
   output logic            room,
   output logic            out_valid,
   input  wire logic       out_ready,
   output result_type      out_data
);
   result_type slot_ff [3];
   result_type slot_in [3];
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[0];
   assign pop       = out_valid & out_ready;
   // room for two more after this cycle's pop
   assign room      = (count_ff == 2'd0) || (count_ff == 2'd1 && pop);

   // shift out, then append
   always_comb begin
      logic [1:0] base;
      slot_in  = slot_ff;
      base     = count_ff;
      if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         base       = count_ff - 2'd1;
      end
      if (push0) begin
         slot_in[base] = data0;
      end
      if (push1) begin
         slot_in[base + 2'd1] = data1;
      end
      count_in = base + {1'b0, push0} + {1'b0, push1};
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      push0 |-> count_in <= 2'd2) else $error("result queue overflow");
   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0) else $error("second result without first");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire

// ===== hdl/ymodem_image_receiver.sv =====
// YMODEM image receiver (CRC-16 blocks): protocol engine and result queue.
// Depends on ymr_pkg, ymr_if and ymr_out_queue.
//
// Usage: req_ carries one transaction per input item: func (start, received
// byte, burst end, millisecond tick) and rx_byte. rsp_ carries result items
// (reply byte, staged flash write, commit/discard, status); an input gives
// zero, one or two results, the final one marked by last. csr_ writes the
// five configuration registers by index; the user must write them only while
// the block is idle, which the block does not enforce. Throughput: one item
// per cycle while rsp_ keeps up; each item is fully processed in the cycle it
// is taken, and its results enter a two-entry queue. An item that gives two
// results holds req_ready low while both are queued. Stall: req_ready falls
// whenever the queue cannot take two more results; while rsp_ is stalled the
// queue fills and input waits; nothing is dropped. Reset: synchronous, active
// high; the session goes idle and configuration returns to its defaults (max
// size 65536, base 0, waits 1000, retries 180).
`default_nettype none
module ymodem_image_receiver
   import ymr_pkg::*;
#(
   parameter int unsigned TIMER_BITS = TimerBitsDefault,
   parameter int unsigned SIZE_BITS  = SizeBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_tx_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_wr_valid,
   output logic [31:0]      rsp_wr_address,
   output logic [7:0]       rsp_wr_byte,
   output logic             rsp_commit_valid,
   output logic             rsp_commit_accept,
   output logic [2:0]       rsp_session_status,
   output logic [31:0]      rsp_image_size,
   output logic [31:0]      rsp_image_crc,
   output logic             rsp_last,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   localparam logic [TIMER_BITS-1:0] TimerMax = '1;
   localparam logic [SIZE_BITS-1:0]  SizeMax  = '1;

   // configuration registers
   logic [31:0] size_limit_ff, base_ff;
   logic [15:0] head_wait_ff, data_wait_ff;
   logic [7:0]  retry_lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff <= 32'd65536;
         base_ff       <= 32'd0;
         head_wait_ff  <= 16'd1000;
         data_wait_ff  <= 16'd1000;
         retry_lim_ff  <= 8'd180;
      end else if (csr_write) begin
         case (csr_index)
            REG_MAX_SIZE:  size_limit_ff <= csr_data;
            REG_BASE:      base_ff       <= csr_data;
            REG_HEAD_WAIT: head_wait_ff  <= csr_data[15:0];
            REG_DATA_WAIT: data_wait_ff  <= csr_data[15:0];
            REG_RETRY:     retry_lim_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // protocol state
   phase_type             phase_ff, phase_in;
   logic [7:0]            eseq_ff, eseq_in;
   logic [31:0]           rsize_ff, rsize_in, esize_ff, esize_in;
   logic [31:0]           icrc_ff, icrc_in, bcrc_ff, bcrc_in;
   logic [15:0]           crc16_ff, crc16_in, rcrc_ff, rcrc_in;
   logic [10:0]           idx_ff, idx_in;
   logic [7:0]            sb_ff, sb_in, seq_ff, seq_in, cmp_ff, cmp_in;
   logic [7:0]            fdb_ff, fdb_in, b2_ff, b2_in;
   hfield_type            hf_ff, hf_in;
   logic [SIZE_BITS-1:0]  psize_ff, psize_in;
   logic [7:0]            retry_ff, retry_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  pend_ff, pend_in;

   ymr_if #(.PAYLOAD_TYPE(result_type)) rsp_ch ();

   logic       room, take, push0, push1;
   result_type r0, r1;

   assign req_ready = room;
   assign take      = req_valid & room;

   // block length from start byte
   function automatic logic [10:0] blk_len(input logic [7:0] s);
      case (s)
         CH_SOH:  return 11'd128;
         CH_STX:  return 11'd1024;
         default: return 11'd0;
      endcase
   endfunction

   function automatic result_type tx_res(input logic [7:0] b, input logic [31:0] sz);
      result_type r;
      r = '0;
      r.tx_valid   = 1'b1;
      r.tx_byte    = b;
      r.image_size = sz;
      return r;
   endfunction

   logic        seq_ok, cand, stg;
   logic [10:0] blen;
   logic [31:0] remain;

   assign blen   = blk_len(sb_ff);
   assign seq_ok = ((seq_ff ^ cmp_ff) == 8'hFF);
   assign cand   = (phase_ff == PH_DATA) && (blen != 11'd0) && seq_ok && (seq_ff == eseq_ff);
   assign remain = esize_ff - rsize_ff;
   assign stg    = cand && (idx_ff >= 11'd4) && (rsize_ff < esize_ff);

   // one input item per cycle while the result queue has room
   always_comb begin
      logic        clr;
      logic        valid_blk, dig;
      logic [10:0] d;
      logic [35:0] prod;
      logic [7:0]  b;
      logic [15:0] lim;
      logic [TIMER_BITS-1:0] tnext;
      hfield_type  hf;
      logic [31:0] w;

      phase_in = phase_ff; eseq_in = eseq_ff; rsize_in = rsize_ff; esize_in = esize_ff;
      icrc_in = icrc_ff; bcrc_in = bcrc_ff; crc16_in = crc16_ff; rcrc_in = rcrc_ff;
      idx_in = idx_ff; sb_in = sb_ff; seq_in = seq_ff; cmp_in = cmp_ff;
      fdb_in = fdb_ff; b2_in = b2_ff; hf_in = hf_ff; psize_in = psize_ff;
      retry_in = retry_ff; timer_in = timer_ff; pend_in = pend_ff;
      push0 = 1'b0; push1 = 1'b0; r0 = '0; r1 = '0;
      clr = 1'b0;
      b = req_rx_byte;
      d = idx_ff - 11'd3;
      valid_blk = 1'b0; dig = 1'b0; prod = '0; hf = hf_ff; w = '0;
      lim = '0; tnext = timer_ff;

      if (take) begin
         case (func_type'(req_func))
            FN_START: begin
               push0 = 1'b1;
               r0 = tx_res(CH_REQ, esize_ff);
               r0.commit_valid = (phase_ff != PH_IDLE) && stg;
               r0.last = 1'b1;
               eseq_in = 8'd1; rsize_in = '0; esize_in = '0; icrc_in = '1;
               retry_in = '0; phase_in = PH_HEAD; clr = 1'b1;
               r0.image_size = 32'd0;
            end
            FN_BYTE: if (phase_ff != PH_IDLE) begin
               pend_in = 1'b1;
               if (idx_ff == 11'd0) begin
                  clr = 1'b1; sb_in = b;
               end else if (idx_ff == 11'd1) begin
                  seq_in = b; b2_in = b;
               end else if (idx_ff == 11'd2) begin
                  cmp_in = b;
               end else if (d < blen) begin
                  if (d == 11'd0) fdb_in = b;
                  crc16_in = crc16_byte(crc16_ff, b);
                  if (phase_ff == PH_HEAD) begin
                     dig = (b >= 8'h30) && (b <= 8'h39);
                     case (hf_ff)
                        HF_NAME:  if (b == 8'd0) hf = HF_ZERO;
                        HF_ZERO:  if (b != 8'd0) hf = dig ? HF_DIGIT : HF_DONE;
                        HF_DIGIT: if (!dig) hf = HF_DONE;
                        default: ;
                     endcase
                     hf_in = hf;
                     if (hf == HF_DIGIT && dig) begin
                        prod = 36'(psize_ff) * 36'd10 + {32'd0, b[3:0]};
                        psize_in = (prod > 36'(SizeMax)) ? SizeMax : prod[SIZE_BITS-1:0];
                     end
                  end
                  if (cand && rsize_ff < esize_ff && {21'd0, d} < remain) begin
                     bcrc_in = crc32_byte(bcrc_ff, b);
                     push0 = 1'b1;
                     r0.wr_valid = 1'b1;
                     r0.wr_address = base_ff + rsize_ff + {21'd0, d};
                     r0.wr_byte = b;
                     r0.image_size = esize_ff;
                     r0.last = 1'b1;
                  end
               end else if (d == blen) begin
                  rcrc_in = {b, 8'd0};
               end else if (d == blen + 11'd1) begin
                  rcrc_in = {rcrc_ff[15:8], b};
               end
               if (idx_ff < IDX_MAX) idx_in = idx_ff + 11'd1;
            end
            FN_END: if (phase_ff != PH_IDLE) begin
               valid_blk = (blen != 11'd0) && (idx_ff >= blen + 11'd5) && seq_ok &&
                           (crc16_ff == rcrc_ff);
               push0 = 1'b1;
               clr = 1'b1;
               if (idx_ff >= 11'd2 && sb_ff == CH_CAN && b2_ff == CH_CAN) begin
                  r0 = '0; r0.session_status = ST_CANCEL; r0.image_size = esize_ff;
                  phase_in = PH_IDLE; clr = 1'b0;
               end else if (idx_ff == 11'd1 && sb_ff == CH_EOT) begin
                  if (phase_ff == PH_EOT) begin
                     r0 = tx_res(CH_ACK, esize_ff);
                     r1 = tx_res(CH_REQ, esize_ff);
                     push1 = 1'b1;
                  end else begin
                     if (phase_ff == PH_DATA) phase_in = PH_EOT;
                     r0 = tx_res(CH_NAK, esize_ff);
                  end
               end else if (!valid_blk) begin
                  r0 = tx_res(CH_NAK, esize_ff);
                  r0.commit_valid = stg;
               end else if (phase_ff == PH_HEAD && seq_ff == 8'd0) begin
                  esize_in = 32'(psize_ff);
                  if (psize_ff == '0 || 32'(psize_ff) > size_limit_ff) begin
                     r0 = '0; r0.session_status = ST_RANGE; r0.image_size = 32'(psize_ff);
                     phase_in = PH_IDLE; clr = 1'b0;
                  end else begin
                     icrc_in = '1; eseq_in = 8'd1; retry_in = '0; phase_in = PH_DATA;
                     r0 = tx_res(CH_ACK, 32'(psize_ff));
                     r1 = tx_res(CH_REQ, 32'(psize_ff));
                     push1 = 1'b1;
                  end
               end else if (phase_ff == PH_EOT && seq_ff == 8'd0 && fdb_ff == 8'd0) begin
                  r0 = tx_res(CH_ACK, esize_ff);
                  if (rsize_ff == esize_ff) begin
                     r0.session_status = ST_OK; r0.image_crc = ~icrc_ff;
                  end else begin
                     r0.session_status = ST_MISMATCH;
                  end
                  phase_in = PH_IDLE; clr = 1'b0;
               end else if (phase_ff != PH_DATA) begin
                  r0 = tx_res(CH_NAK, esize_ff);
               end else if (seq_ff == eseq_ff - 8'd1) begin
                  r0 = tx_res(CH_ACK, esize_ff);
               end else if (seq_ff != eseq_ff) begin
                  r0 = tx_res(CH_NAK, esize_ff);
               end else begin
                  if (rsize_ff < esize_ff) begin
                     w = (remain > {21'd0, blen}) ? {21'd0, blen} : remain;
                     rsize_in = rsize_ff + w;
                     icrc_in = bcrc_ff;
                  end
                  eseq_in = eseq_ff + 8'd1;
                  r0 = tx_res(CH_ACK, esize_ff);
                  r0.commit_valid = stg; r0.commit_accept = stg;
               end
               if (push1) r1.last = 1'b1; else r0.last = 1'b1;
            end
            FN_TICK: if (phase_ff != PH_IDLE) begin
               lim = (phase_ff == PH_HEAD) ? head_wait_ff : data_wait_ff;
               tnext = (timer_ff < TimerMax) ? timer_ff + 1'b1 : timer_ff;
               timer_in = tnext;
               if (32'(tnext) >= 32'(lim)) begin
                  if (phase_ff == PH_HEAD && pend_ff) begin
                     timer_in = '0;
                  end else if (phase_ff == PH_HEAD && retry_ff < retry_lim_ff) begin
                     retry_in = retry_ff + 8'd1; timer_in = '0;
                     push0 = 1'b1; r0 = tx_res(CH_REQ, esize_ff); r0.last = 1'b1;
                  end else begin
                     push0 = 1'b1; r0 = '0; r0.session_status = ST_TIMEOUT;
                     r0.commit_valid = stg; r0.image_size = esize_ff; r0.last = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
         // start of a fresh frame
         if (clr) begin
            idx_in = (func_type'(req_func) == FN_BYTE) ? 11'd1 : 11'd0;
            if (func_type'(req_func) != FN_BYTE) sb_in = '0;
            seq_in = '0; b2_in = '0; cmp_in = '0; rcrc_in = '0; fdb_in = '0;
            crc16_in = '0; hf_in = HF_NAME; psize_in = '0;
            bcrc_in = icrc_in; pend_in = (func_type'(req_func) == FN_BYTE);
            timer_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; eseq_ff <= 8'd1; rsize_ff <= '0; esize_ff <= '0;
         icrc_ff <= '1; bcrc_ff <= '1; crc16_ff <= '0; rcrc_ff <= '0;
         idx_ff <= '0; sb_ff <= '0; seq_ff <= '0; cmp_ff <= '0;
         fdb_ff <= '0; b2_ff <= '0; hf_ff <= HF_NAME; psize_ff <= '0;
         retry_ff <= '0; timer_ff <= '0; pend_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; eseq_ff <= eseq_in; rsize_ff <= rsize_in;
         esize_ff <= esize_in; icrc_ff <= icrc_in; bcrc_ff <= bcrc_in;
         crc16_ff <= crc16_in; rcrc_ff <= rcrc_in; idx_ff <= idx_in;
         sb_ff <= sb_in; seq_ff <= seq_in; cmp_ff <= cmp_in; fdb_ff <= fdb_in;
         b2_ff <= b2_in; hf_ff <= hf_in; psize_ff <= psize_in;
         retry_ff <= retry_in; timer_ff <= timer_in; pend_ff <= pend_in;
      end
   end

   ymr_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .push1     (push1),
      .data0     (r0),
      .data1     (r1),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_ch.payload)
   );

   assign rsp_ch.ready       = rsp_ready;
   assign rsp_valid          = rsp_ch.valid;
   assign rsp_tx_valid       = rsp_ch.payload.tx_valid;
   assign rsp_tx_byte        = rsp_ch.payload.tx_byte;
   assign rsp_wr_valid       = rsp_ch.payload.wr_valid;
   assign rsp_wr_address     = rsp_ch.payload.wr_address;
   assign rsp_wr_byte        = rsp_ch.payload.wr_byte;
   assign rsp_commit_valid   = rsp_ch.payload.commit_valid;
   assign rsp_commit_accept  = rsp_ch.payload.commit_accept;
   assign rsp_session_status = rsp_ch.payload.session_status;
   assign rsp_image_size     = rsp_ch.payload.image_size;
   assign rsp_image_crc      = rsp_ch.payload.image_crc;
   assign rsp_last           = rsp_ch.payload.last;

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE && take && req_func != FN_START) |-> !push0)
      else $error("result from idle without start");
   a_start_head: assert property (@(posedge clock) disable iff (reset)
      (take && req_func == FN_START) |=> phase_ff == PH_HEAD)
      else $error("start did not enter header phase");
   a_size_cap: assert property (@(posedge clock) disable iff (reset)
      rsize_ff <= esize_ff) else $error("received size exceeds image size");
endmodule
`default_nettype wire
